// File: hdl/rllt_pkg.sv
// ----------------------------------------------------------------------------
// rllt_pkg: shared types and constants of the run-length line table
// Table sizes, field widths, command and status codes, controller states and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package rllt_pkg;

   localparam int PAIR_DEPTH = 256;
   localparam int PAIR_AW    = $clog2(PAIR_DEPTH);
   localparam int CNT_W      = $clog2(PAIR_DEPTH + 1);
   localparam int LINE_W     = 16;
   localparam int IDX_W      = 16;
   localparam int RUN_W      = 16;
   localparam int ENTRY_W    = RUN_W + LINE_W;

   localparam logic [RUN_W-1:0] RUN_LIMIT  = '1;
   localparam logic [IDX_W-1:0] BYTE_LIMIT = '1;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_DROP  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPEND,
      ST_LOOK_START,
      ST_LOOK_WALK,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic capture;
      logic append;
      logic look_start;
      logic walk;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic range_err;
      logic hit;
      logic rsp_free;
   } dp_stat_type;

endpackage

// File: hdl/rllt_ram.sv
// ----------------------------------------------------------------------------
// rllt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rllt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/rllt_ctrl.sv
// ----------------------------------------------------------------------------
// rllt_ctrl: controller of the run-length line table
// Sequences accept, append update, lookup walk and result transfer.
// ----------------------------------------------------------------------------
module rllt_ctrl import rllt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_command,
   output logic        req_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_command == CMD_LOOKUP) ? ST_LOOK_START : ST_APPEND;
            end
         end
         ST_APPEND: begin
            cmd.append = 1'b1;
            state_in   = ST_REPLY;
         end
         ST_LOOK_START: begin
            cmd.look_start = 1'b1;
            state_in       = stat.range_err ? ST_REPLY : ST_LOOK_WALK;
         end
         ST_LOOK_WALK: begin
            cmd.walk = 1'b1;
            if (stat.hit) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/rllt_dp.sv
// ----------------------------------------------------------------------------
// rllt_dp: datapath of the run-length line table
// Pair memory, last-pair copy, counters, lookup accumulator and result register.
// ----------------------------------------------------------------------------
module rllt_dp import rllt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_stat_type       stat,
   input  logic [LINE_W-1:0] req_line_number,
   input  logic [IDX_W-1:0]  req_instruction_index,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [LINE_W-1:0] rsp_found_line,
   output logic [1:0]        rsp_status
);

   logic [LINE_W-1:0]  line_ff;
   logic [IDX_W-1:0]   index_ff;
   logic [CNT_W-1:0]   pair_cnt_ff;
   logic [IDX_W-1:0]   total_ff;
   logic [LINE_W-1:0]  last_line_ff;
   logic [RUN_W-1:0]   last_count_ff;
   logic [PAIR_AW-1:0] walk_addr_ff;
   logic [IDX_W-1:0]   sum_ff;
   logic [LINE_W-1:0]  res_line_ff;
   logic [1:0]         res_status_ff;
   logic               rsp_valid_ff;
   logic [LINE_W-1:0]  rsp_line_ff;
   logic [1:0]         rsp_status_ff;

   logic               byte_full;
   logic               extend;
   logic               table_full;
   logic               app_ok;
   logic [CNT_W-1:0]   last_idx;
   logic               wr_en;
   logic [PAIR_AW-1:0] wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [PAIR_AW-1:0] rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic [RUN_W-1:0]   rd_count;
   logic [LINE_W-1:0]  rd_line;
   logic [IDX_W:0]     sum_next;
   logic [RUN_W-1:0]   new_count;

   assign byte_full  = (total_ff == BYTE_LIMIT);
   assign extend     = (pair_cnt_ff != '0) && (last_line_ff == line_ff)
                       && (last_count_ff != RUN_LIMIT);
   assign table_full = (pair_cnt_ff == CNT_W'(PAIR_DEPTH));
   assign app_ok     = !byte_full && (extend || !table_full);
   assign last_idx   = pair_cnt_ff - CNT_W'(1);
   assign new_count  = extend ? (last_count_ff + RUN_W'(1)) : RUN_W'(1);

   assign wr_en   = cmd.append && app_ok;
   assign wr_addr = extend ? last_idx[PAIR_AW-1:0] : pair_cnt_ff[PAIR_AW-1:0];
   assign wr_data = {new_count, line_ff};
   assign rd_addr = cmd.look_start ? '0 : walk_addr_ff;

   rllt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PAIR_DEPTH)
   ) u_pairs (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_count = rd_data[ENTRY_W-1:LINE_W];
   assign rd_line  = rd_data[LINE_W-1:0];
   assign sum_next = {1'b0, sum_ff} + {1'b0, rd_count};

   assign stat.range_err = (index_ff >= total_ff);
   assign stat.hit       = (sum_next > {1'b0, index_ff});
   assign stat.rsp_free  = !rsp_valid_ff || !rsp_stall;

   // table bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         pair_cnt_ff  <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            total_ff <= total_ff + IDX_W'(1);
            if (!extend) begin
               pair_cnt_ff <= pair_cnt_ff + CNT_W'(1);
            end
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         line_ff  <= req_line_number;
         index_ff <= req_instruction_index;
      end
      if (wr_en) begin
         last_line_ff  <= line_ff;
         last_count_ff <= new_count;
      end
      if (cmd.append) begin
         res_line_ff   <= '0;
         res_status_ff <= app_ok ? STAT_OK : STAT_DROP;
      end
      if (cmd.look_start) begin
         walk_addr_ff  <= PAIR_AW'(1);
         sum_ff        <= '0;
         res_line_ff   <= '0;
         res_status_ff <= STAT_RANGE;
      end
      if (cmd.walk) begin
         walk_addr_ff <= walk_addr_ff + PAIR_AW'(1);
         if (stat.hit) begin
            res_line_ff   <= rd_line;
            res_status_ff <= STAT_OK;
         end else begin
            sum_ff <= sum_next[IDX_W-1:0];
         end
      end
      if (cmd.load_rsp) begin
         rsp_line_ff   <= res_line_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found_line = rsp_line_ff;
   assign rsp_status     = rsp_status_ff;

   a_pair_bound: assert property (@(posedge clock) disable iff (reset)
      pair_cnt_ff <= CNT_W'(PAIR_DEPTH))
      else $error("pair count beyond table depth");

   a_walk_sum: assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> sum_ff <= index_ff)
      else $error("lookup sum passed the index");

   a_append_total: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> total_ff == $past(total_ff) + IDX_W'(1))
      else $error("accepted append did not advance byte total");

endmodule

// File: hdl/run_length_line_table.sv
// ----------------------------------------------------------------------------
// run_length_line_table: run-length map from recorded code bytes to lines
// Appends grow or open (count, line) pairs; lookups walk the pairs to find
// the line of a byte index.
//
//   channel  direction  ports
//   req      in         req_valid, req_stall, req_command, req_line_number,
//                       req_instruction_index
//   rsp      out        rsp_valid, rsp_stall, rsp_found_line, rsp_status
//
// An append passes accept, table update and result load. A lookup passes
// accept, range check, the walk up to the matching pair (position 1 up to
// PAIR_DEPTH) and result load; the single read port of the pair memory
// walks one pair per cycle. An out-of-range lookup skips the walk.
// Reset clears the pair count and byte total; the pair memory is not cleared.
// A new request is taken while a finished result waits under rsp_stall.
// ----------------------------------------------------------------------------
module run_length_line_table import rllt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_command,
   input  logic [LINE_W-1:0] req_line_number,
   input  logic [IDX_W-1:0]  req_instruction_index,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [LINE_W-1:0] rsp_found_line,
   output logic [1:0]        rsp_status
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   rllt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .stat        (stat),
      .cmd         (cmd)
   );

   rllt_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_line_number       (req_line_number),
      .req_instruction_index (req_instruction_index),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_found_line        (rsp_found_line),
      .rsp_status            (rsp_status)
   );

endmodule
